FILE: hdl/gwm_pkg.sv
package gwm_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_TEXT   = 2'd1,
    CMD_END    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] character;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

  localparam logic [7:0] STAR_CHAR     = 8'h2A;
  localparam logic [7:0] QUESTION_CHAR = 8'h3F;
  localparam logic [7:0] UPPER_A       = 8'h41;
  localparam logic [7:0] UPPER_Z       = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold_en);
    if (fold_en && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

FILE: hdl/gwm_closure.sv
// Star closure as a log-depth prefix: a set bit moves across any run of stars.
module gwm_closure #(
  parameter int N = 33
) (
  input  logic [N-1:0] seed,
  input  logic [N-2:0] star,
  output logic [N-1:0] closed
);

  localparam int STEPS = $clog2(N);

  logic [N-1:0] g [STEPS+1];
  logic [N-1:0] p [STEPS];

  assign g[0] = seed;
  assign p[0] = {star, 1'b0};

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int D = 1 << s;
    assign g[s+1] = g[s] | ((g[s] << D) & p[s]);
    if (s + 1 < STEPS) begin : g_prop
      assign p[s+1] = p[s] & (p[s] << D);
    end
  end

  assign closed = g[STEPS];

endmodule

FILE: hdl/glob_wildcard_matcher_unit.sv
// An accepted end item is held in the s1 item register, then its result is registered on the result port.
// Throughput: 1 item per cycle unless stalled; the active-position set updates fully for each item.
// Only an end item can stall, and only while the result register is still held.
// Reset (synchronous, rst high): pattern empty, overflow clear, case folding on,
// active set at the start position, no result pending. Pattern bytes are not cleared.
module glob_wildcard_matcher_unit
  import gwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_wen,
  input  logic    cfg_wdata,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int N     = PATTERN_MAX + 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic             case_insensitive;
  logic             s1_valid;
  item_t            s1_item;
  logic [7:0]       store [PATTERN_MAX];
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  logic             overflow;
  logic             overflow_next;
  logic [N-1:0]     active;

  logic             s1_go;
  logic             append_ok;
  logic [PATTERN_MAX-1:0] len_mask;
  logic [PATTERN_MAX-1:0] star_now;
  logic [PATTERN_MAX-1:0] star_next;
  logic [PATTERN_MAX-1:0] hit;
  logic [N-1:0]     adv;
  logic [N-1:0]     seed;
  logic [N-1:0]     closed;
  logic [7:0]       text_folded;

  assign s1_go = s1_valid &&
                 (s1_item.command != CMD_END || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;
  assign append_ok  = length < LEN_W'(PATTERN_MAX);
  assign text_folded = fold_char(s1_item.character, case_insensitive);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      len_mask[i] = LEN_W'(i) < length;
      star_now[i] = len_mask[i] && store[i] == STAR_CHAR;
      hit[i]      = len_mask[i] &&
                    (store[i] == QUESTION_CHAR ||
                     fold_char(store[i], case_insensitive) == text_folded);
    end
  end

  always_comb begin
    adv = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (active[i] && star_now[i]) begin
        adv[i] = 1'b1;
      end
      if (active[i] && !star_now[i] && hit[i]) begin
        adv[i+1] = 1'b1;
      end
    end
  end

  always_comb begin
    length_next   = length;
    overflow_next = overflow;
    star_next     = star_now;
    unique case (s1_item.command)
      CMD_APPEND: begin
        if (append_ok) begin
          length_next = length + LEN_W'(1);
          for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LEN_W'(i) == length) begin
              star_next[i] = s1_item.character == STAR_CHAR;
            end
          end
        end else begin
          overflow_next = 1'b1;
        end
      end
      CMD_TEXT, CMD_END: begin
      end
      CMD_CLEAR: begin
        length_next   = '0;
        overflow_next = 1'b0;
        star_next     = '0;
      end
    endcase
  end

  assign seed = (s1_item.command == CMD_TEXT) ? adv : N'(1);

  gwm_closure #(.N(N)) u_closure (
    .seed   (seed),
    .star   (star_next),
    .closed (closed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      case_insensitive <= 1'b1;
      s1_valid         <= 1'b0;
      length           <= '0;
      overflow         <= 1'b0;
      active           <= N'(1);
      result_valid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case_insensitive <= cfg_wdata;
      end
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s1_go) begin
        length   <= length_next;
        overflow <= overflow_next;
        active   <= closed;
      end
      if (s1_go && s1_item.command == CMD_END) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      s1_item <= item;
    end
    if (s1_go && s1_item.command == CMD_END) begin
      result.matched          <= active[length];
      result.pattern_overflow <= overflow;
    end
    if (s1_go && s1_item.command == CMD_APPEND && append_ok) begin
      store[length[IDX_W-1:0]] <= s1_item.character;
    end
  end

endmodule

FILE: hdl/gwm_checker.sv
module gwm_props
  import gwm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      $past(item_valid && item_ready && item.command == CMD_END, 2))
    else $error("result without a matching end item");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled while result side free");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result pending after reset");

endmodule

bind glob_wildcard_matcher_unit gwm_props u_gwm_props (.*);
